/* rtl/core/scaled_decimal_alu_top_defines.svh */
// assertion macros for the scaled decimal alu checker
// used by sda_checker.sv; needs clk and rst_n in the enclosing scope
`ifndef SCALED_DECIMAL_ALU_TOP_DEFINES_SVH
`define SCALED_DECIMAL_ALU_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sda check failed");

// next-cycle implication, disabled in reset
`define SDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sda check failed");

`endif

/* rtl/core/sda_pkg.sv */
// types and constants for the scaled decimal alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sda_pkg;

  localparam int unsigned DW = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  // payload that rides along the divider stages
  typedef struct packed {
    logic [2:0]    op;
    logic          nul;
    logic [DW-1:0] lv;
    logic [DW-1:0] rv;
    logic          same;
    logic          lt;
    logic [5:0]    scale;
    logic [DW-1:0] pre_val;
    logic [1:0]    status;
    logic          divz;
    logic          qneg;
    logic          dneg;
  } side_t;

  function automatic logic [DW-1:0] pow10(input logic [4:0] idx);
    logic [DW-1:0] p;
    unique case (idx)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scaled_decimal_alu_top.sv */
// scaled decimal alu: add, subtract, multiply, divide, compare
// depends on sda_pkg
// throughput: one item per cycle when not stalled; the 64 stage restoring divider and the
//   split 32 bit partial product multiplier are fully pipelined
// stall: whole pipeline holds while the output item waits
// reset: rst_n synchronous active low clears all valid bits
`timescale 1ns / 1ps
`default_nettype none

module scaled_decimal_alu_top #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_SCALE   = 18
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // left_value, left_scale, left_null, right_value, right_scale, right_null, pad
  input  wire logic [143:0] in_tdata,
  // mode
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_value, result_scale, order, status, pad
  output logic [79:0]       out_tdata
);
  import sda_pkg::*;

  localparam int SH = DW - VALUE_WIDTH;
  localparam logic [4:0] MAXS = 5'(MAX_SCALE);

  function automatic logic [DW-1:0] wrapv(input logic [DW-1:0] x);
    return DW'($signed(x << SH) >>> SH);
  endfunction

  function automatic logic [4:0] clampv(input logic [4:0] s);
    return (s > MAXS) ? MAXS : s;
  endfunction

  logic adv;
  logic out_valid_r;
  logic [DW-1:0] out_value_r;
  logic [5:0] out_scale_r;
  logic [1:0] out_order_r;
  logic [1:0] out_status_r;

  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, out_status_r, out_order_r, out_scale_r, out_value_r};

  // stage 1: input register
  logic s1_valid_r;
  logic [2:0] s1_op_r;
  logic [DW-1:0] s1_lv_r, s1_rv_r;
  logic [4:0] s1_ls_r, s1_rs_r;
  logic s1_nul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
    if (adv) begin
      s1_op_r  <= in_tuser;
      s1_lv_r  <= wrapv(in_tdata[63:0]);
      s1_ls_r  <= clampv(in_tdata[68:64]);
      s1_rv_r  <= wrapv(in_tdata[133:70]);
      s1_rs_r  <= clampv(in_tdata[138:134]);
      s1_nul_r <= in_tdata[69] | in_tdata[139];
    end
  end

  // stage 2: partial products
  logic s1_lt;
  logic [4:0] s1_diff;
  logic [DW-1:0] s1_p, mul_a, mul_b;
  logic [63:0] pp_ll_nxt;
  logic [31:0] pp_lh_nxt, pp_hl_nxt;

  always_comb begin
    s1_lt   = s1_ls_r < s1_rs_r;
    s1_diff = s1_lt ? (s1_rs_r - s1_ls_r) : (s1_ls_r - s1_rs_r);
    s1_p    = pow10(s1_diff);
    if (s1_op_r == OP_MUL) begin
      mul_a = s1_lv_r;
      mul_b = s1_rv_r;
    end else begin
      mul_a = s1_lt ? s1_lv_r : s1_rv_r;
      mul_b = s1_p;
    end
    pp_ll_nxt = mul_a[31:0] * mul_b[31:0];
    pp_lh_nxt = mul_a[31:0] * mul_b[63:32];
    pp_hl_nxt = mul_a[63:32] * mul_b[31:0];
  end

  logic s2_valid_r;
  logic [2:0] s2_op_r;
  logic [DW-1:0] s2_lv_r, s2_rv_r, s2_p_r;
  logic [4:0] s2_ls_r, s2_rs_r;
  logic s2_nul_r, s2_lt_r;
  logic [63:0] s2_ll_r;
  logic [31:0] s2_lh_r, s2_hl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      s2_op_r  <= s1_op_r;
      s2_lv_r  <= s1_lv_r;
      s2_rv_r  <= s1_rv_r;
      s2_ls_r  <= s1_ls_r;
      s2_rs_r  <= s1_rs_r;
      s2_nul_r <= s1_nul_r;
      s2_lt_r  <= s1_lt;
      s2_p_r   <= s1_p;
      s2_ll_r  <= pp_ll_nxt;
      s2_lh_r  <= pp_lh_nxt;
      s2_hl_r  <= pp_hl_nxt;
    end
  end

  // stage 3: product sum and alignment
  logic [DW-1:0] prod_nxt, a_nxt, b_nxt;
  logic [5:0] sc_nxt;

  always_comb begin
    prod_nxt = wrapv(s2_ll_r + {s2_lh_r + s2_hl_r, 32'd0});
    if (s2_op_r == OP_MUL) begin
      a_nxt  = s2_lv_r;
      b_nxt  = s2_rv_r;
      sc_nxt = {1'b0, s2_ls_r} + {1'b0, s2_rs_r};
    end else if (s2_lt_r) begin
      a_nxt  = prod_nxt;
      b_nxt  = s2_rv_r;
      sc_nxt = {1'b0, s2_rs_r};
    end else begin
      a_nxt  = s2_lv_r;
      b_nxt  = prod_nxt;
      sc_nxt = {1'b0, s2_ls_r};
    end
  end

  logic s3_valid_r;
  logic [2:0] s3_op_r;
  logic [DW-1:0] s3_lv_r, s3_rv_r, s3_p_r, s3_a_r, s3_b_r, s3_prod_r;
  logic [4:0] s3_ls_r;
  logic s3_nul_r, s3_lt_r, s3_same_r;
  logic [5:0] s3_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
    if (adv) begin
      s3_op_r   <= s2_op_r;
      s3_lv_r   <= s2_lv_r;
      s3_rv_r   <= s2_rv_r;
      s3_ls_r   <= s2_ls_r;
      s3_nul_r  <= s2_nul_r;
      s3_lt_r   <= s2_lt_r;
      s3_same_r <= s2_ls_r == s2_rs_r;
      s3_p_r    <= s2_p_r;
      s3_a_r    <= a_nxt;
      s3_b_r    <= b_nxt;
      s3_sc_r   <= sc_nxt;
      s3_prod_r <= prod_nxt;
    end
  end

  // stage 4: add/sub/mul result, null passthrough and divider setup
  side_t side_nxt;
  logic [DW-1:0] dend_nxt, dvs_nxt, dsel;

  always_comb begin
    side_nxt.op      = s3_op_r;
    side_nxt.nul     = s3_nul_r;
    side_nxt.lv      = s3_lv_r;
    side_nxt.rv      = s3_rv_r;
    side_nxt.same    = s3_same_r;
    side_nxt.lt      = s3_lt_r;
    side_nxt.scale   = 6'd0;
    side_nxt.pre_val = '0;
    side_nxt.status  = ST_OK;
    side_nxt.divz    = 1'b0;
    side_nxt.qneg    = 1'b0;
    side_nxt.dneg    = 1'b0;
    dsel             = s3_a_r;
    dvs_nxt          = s3_b_r[DW-1] ? (DW'(0) - s3_b_r) : s3_b_r;
    if (s3_op_r > OP_CMP) begin
      side_nxt.scale = 6'd0;
    end else if (s3_nul_r) begin
      side_nxt.pre_val = s3_lv_r;
      side_nxt.scale   = {1'b0, s3_ls_r};
      side_nxt.status  = ST_NULL;
    end else begin
      unique case (s3_op_r)
        OP_ADD: begin
          side_nxt.pre_val = wrapv(s3_a_r + s3_b_r);
          side_nxt.scale   = s3_sc_r;
        end
        OP_SUB: begin
          side_nxt.pre_val = wrapv(s3_a_r - s3_b_r);
          side_nxt.scale   = s3_sc_r;
        end
        OP_MUL: begin
          side_nxt.pre_val = s3_prod_r;
          side_nxt.scale   = s3_sc_r;
        end
        OP_DIV: begin
          side_nxt.scale = s3_sc_r;
          side_nxt.divz  = s3_b_r == '0;
          side_nxt.qneg  = s3_a_r[DW-1] ^ s3_b_r[DW-1];
          if (s3_b_r == '0) side_nxt.status = ST_DIVZ;
        end
        default: begin
          dsel    = s3_lt_r ? s3_rv_r : s3_lv_r;
          dvs_nxt = s3_p_r;
          side_nxt.qneg = dsel[DW-1];
        end
      endcase
    end
    side_nxt.dneg = dsel[DW-1];
    dend_nxt = dsel[DW-1] ? (DW'(0) - dsel) : dsel;
  end

  // restoring divider, one quotient bit per stage
  logic          dv_valid_r [0:DW];
  logic [DW-1:0] dv_rem_r   [0:DW];
  logic [DW-1:0] dv_dq_r    [0:DW];
  logic [DW-1:0] dv_dvs_r   [0:DW];
  side_t         dv_side_r  [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= s3_valid_r;
    end
    if (adv) begin
      dv_rem_r[0]  <= '0;
      dv_dq_r[0]   <= dend_nxt;
      dv_dvs_r[0]  <= dvs_nxt;
      dv_side_r[0] <= side_nxt;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        qbit;

    always_comb begin
      trial = {dv_rem_r[k], dv_dq_r[k][DW-1]};
      diff  = trial - {1'b0, dv_dvs_r[k]};
      qbit  = !diff[DW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
      if (adv) begin
        dv_rem_r[k+1]  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        dv_dq_r[k+1]   <= {dv_dq_r[k][DW-2:0], qbit};
        dv_dvs_r[k+1]  <= dv_dvs_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // output stage: quotient sign, compare decision
  side_t fs;
  logic [DW-1:0] qs;
  logic remnz, mpos, mneg;
  logic [DW-1:0] value_nxt;
  logic [1:0] order_nxt;

  always_comb begin
    fs        = dv_side_r[DW];
    qs        = fs.qneg ? (DW'(0) - dv_dq_r[DW]) : dv_dq_r[DW];
    remnz     = dv_rem_r[DW] != '0;
    mpos      = !fs.dneg && remnz;
    mneg      = fs.dneg && remnz;
    value_nxt = fs.pre_val;
    order_nxt = ORD_EQ;
    if (fs.op == OP_DIV && !fs.nul && !fs.divz) value_nxt = wrapv(qs);
    if (fs.op == OP_CMP && !fs.nul) begin
      priority if (fs.same) begin
        if ($signed(fs.lv) > $signed(fs.rv)) order_nxt = ORD_GT;
        else if (fs.lv == fs.rv) order_nxt = ORD_EQ;
        else order_nxt = ORD_LT;
      end else if (fs.lv[DW-1] && !fs.rv[DW-1]) begin
        order_nxt = ORD_LT;
      end else if (!fs.lv[DW-1] && fs.rv[DW-1]) begin
        order_nxt = ORD_GT;
      end else if (fs.lt) begin
        if ($signed(fs.lv) > $signed(qs)) order_nxt = ORD_GT;
        else if ($signed(fs.lv) < $signed(qs) || mpos) order_nxt = ORD_LT;
        else if (mneg) order_nxt = ORD_GT;
        else order_nxt = ORD_EQ;
      end else begin
        if ($signed(qs) < $signed(fs.rv)) order_nxt = ORD_LT;
        else if ($signed(qs) > $signed(fs.rv) || mpos) order_nxt = ORD_GT;
        else if (mneg) order_nxt = ORD_LT;
        else order_nxt = ORD_EQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[DW];
    end
    if (adv) begin
      out_value_r  <= value_nxt;
      out_scale_r  <= fs.scale;
      out_order_r  <= order_nxt;
      out_status_r <= fs.status;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sda_checker.sv */
// port-level checks for scaled_decimal_alu_top, bound to the top level
// depends on scaled_decimal_alu_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_decimal_alu_top_defines.svh"

module sda_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);
  import sda_pkg::*;

  // stalled output item holds
  `SDA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // ready follows the output stall
  `SDA_ASSERT_NOW(a_ready_stall, out_tvalid && !out_tready, !in_tready)

  // null passthrough never carries an order
  `SDA_ASSERT_NOW(a_null_order, out_tvalid && out_tdata[73:72] == ST_NULL, out_tdata[71:70] == ORD_EQ)

  // divide by zero gives zero with no order
  `SDA_ASSERT_NOW(a_divz_zero, out_tvalid && out_tdata[73:72] == ST_DIVZ, out_tdata[63:0] == 64'd0 && out_tdata[71:70] == ORD_EQ)

endmodule

bind scaled_decimal_alu_top sda_checker u_sda_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// testbench for scaled_decimal_alu_top: directed and random operand pairs
// with random stalls on both sides, checked against a behavioral predictor
// depends on sda_pkg and scaled_decimal_alu_top
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import sda_pkg::*;

  localparam int LATENCY = 69;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    op_t          mode;
    logic [63:0]  lv;
    logic [4:0]   ls;
    logic         lnull;
    logic [63:0]  rv;
    logic [4:0]   rs;
    logic         rnull;
  } operands_t;

  typedef struct {
    logic [63:0] val;
    logic [5:0]  scale;
    logic [1:0]  ord;
    logic [1:0]  status;
  } outcome_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;

  outcome_t expected_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       hold_off;
  int       rx_wait;
  bit       hold_req;
  bit       hold_started;

  scaled_decimal_alu_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [4:0] sat_scale(input logic [4:0] s);
    return (s > 5'd18) ? 5'd18 : s;
  endfunction

  function automatic logic [1:0] compare_scaled(input logic signed [63:0] l, input int sl,
                                                input logic signed [63:0] r, input int sr);
    logic signed [63:0] p, t, m;
    if (sl == sr) return (l > r) ? ORD_GT : ((l == r) ? ORD_EQ : ORD_LT);
    if (l < 0 && r >= 0) return ORD_LT;
    if (l >= 0 && r < 0) return ORD_GT;
    if (sl < sr) begin
      p = ten_to(sr - sl);
      t = r / p;
      m = r % p;
      if (l > t) return ORD_GT;
      if (l < t || m > 0) return ORD_LT;
      if (m < 0) return ORD_GT;
      return ORD_EQ;
    end
    p = ten_to(sl - sr);
    t = l / p;
    m = l % p;
    if (t < r) return ORD_LT;
    if (t > r || m > 0) return ORD_GT;
    if (m < 0) return ORD_LT;
    return ORD_EQ;
  endfunction

  function automatic outcome_t decimal_result(input operands_t x);
    outcome_t o;
    logic [4:0] ls, rs;
    logic [63:0] a, b, ma, mb, q;
    o = '{val: 64'd0, scale: 6'd0, ord: ORD_EQ, status: ST_OK};
    ls = sat_scale(x.ls);
    rs = sat_scale(x.rs);
    if (x.mode > OP_CMP) return o;
    if (x.lnull || x.rnull) begin
      o.val = x.lv;
      o.scale = {1'b0, ls};
      o.status = ST_NULL;
      return o;
    end
    case (x.mode)
      OP_CMP: o.ord = compare_scaled(x.lv, ls, x.rv, rs);
      OP_MUL: begin
        o.val = x.lv * x.rv;
        o.scale = ls + rs;
      end
      default: begin
        a = x.lv;
        b = x.rv;
        if (ls < rs) begin
          a = x.lv * ten_to(rs - ls);
          o.scale = {1'b0, rs};
        end else begin
          b = x.rv * ten_to(ls - rs);
          o.scale = {1'b0, ls};
        end
        if (x.mode == OP_ADD) o.val = a + b;
        else if (x.mode == OP_SUB) o.val = a - b;
        else if (b == 64'd0) o.status = ST_DIVZ;
        else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          q = ma / mb;
          o.val = (a[63] != b[63]) ? -q : q;
        end
      end
    endcase
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // send one item, then idle a random number of cycles
  task automatic send(input operands_t x);
    int gap;
    in_tdata <= {4'd0, x.rnull, x.rs, x.rv, x.lnull, x.ls, x.lv};
    in_tuser <= x.mode;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(decimal_result(x));
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7fff_ffff_ffff_ffff;
      3: return 64'd0;
      4: return -$signed({32'd0, $urandom_range(0, 1000)});
      5: return {32'd0, $urandom_range(0, 1000)};
      6: return {{32{1'b0}}, $urandom};
      default: return -$signed(64'(ten_to($urandom_range(0, 18))) * $urandom_range(1, 9));
    endcase
  endfunction

  function automatic operands_t rand_item();
    operands_t x;
    x.mode = op_t'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
    x.lv = rand_value();
    x.rv = rand_value();
    x.ls = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(19, 31)) : 5'($urandom_range(0, 18));
    x.rs = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(19, 31)) : 5'($urandom_range(0, 18));
    x.lnull = ($urandom_range(0, 9) == 0);
    x.rnull = ($urandom_range(0, 9) == 0);
    return x;
  endfunction

  task automatic test_directed();
    operands_t x;
    logic [63:0] vals[4];
    vals = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd0, 64'hffff_ffff_ffff_ffff};
    for (int m = 0; m < 8; m++) begin
      x = '{op_t'(m), vals[m % 4], 5'd0, 1'b0, vals[(m + 1) % 4], 5'd31, 1'b0};
      send(x);
    end
    send('{OP_DIV, 64'h8000_0000_0000_0000, 5'd3, 1'b0, -64'sd1, 5'd3, 1'b0});
    send('{OP_DIV, 64'd5, 5'd2, 1'b0, 64'd0, 5'd18, 1'b0});
    send('{OP_DIV, -64'sd7, 5'd0, 1'b0, 64'd2, 5'd0, 1'b0});
    send('{OP_CMP, 64'd15, 5'd1, 1'b0, 64'd150, 5'd2, 1'b0});
    send('{OP_CMP, -64'sd151, 5'd2, 1'b0, -64'sd15, 5'd1, 1'b0});
    send('{OP_CMP, -64'sd1, 5'd0, 1'b0, 64'd1, 5'd18, 1'b0});
    send('{OP_CMP, 64'd3, 5'd0, 1'b0, 64'd3, 5'd0, 1'b1});
    send('{OP_ADD, 64'd12, 5'd20, 1'b1, 64'd1, 5'd0, 1'b0});
    send('{OP_MUL, 64'hffff_ffff_ffff_ffff, 5'd18, 1'b0, 64'hffff_ffff_ffff_ffff, 5'd31, 1'b0});
    send('{OP_SUB, 64'd1, 5'd0, 1'b0, 64'd1, 5'd18, 1'b0});
  endtask

  task automatic test_random();
    for (int i = 0; i < 350; i++) send(rand_item());
  endtask

  // long receiver hold-off while items keep coming, fills the pipeline
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 130; i++) begin
      in_tdata <= {4'd0, 1'b0, 5'd3, {$urandom, $urandom}, 1'b0, 5'd7, {$urandom, $urandom}};
      in_tuser <= OP_DIV;
      in_tvalid <= 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      expected_q.push_back(decimal_result('{OP_DIV, in_tdata[63:0], 5'd7, 1'b0,
                                            in_tdata[133:70], 5'd3, 1'b0}));
    end
    in_tvalid <= 1'b0;
  endtask

  // receiver: random wait after each item, one long hold-off on request
  always @(posedge clk) begin
    int w;
    w = 0;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_off <= 0;
      hold_started <= 1'b0;
      rx_wait <= 0;
    end else if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_off <= 300;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
      rx_wait <= (w > 0) ? w - 1 : 0;
      out_tready <= (w == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected item", out_tdata[63:0], 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[63:0] !== want.val) report("result_value", out_tdata[63:0], want.val);
        if (out_tdata[69:64] !== want.scale) report("result_scale", out_tdata[69:64], want.scale);
        if (out_tdata[71:70] !== want.ord) report("order", out_tdata[71:70], want.ord);
        if (out_tdata[73:72] !== want.status) report("status", out_tdata[73:72], want.status);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off > 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/sda_pkg.sv
rtl/core/scaled_decimal_alu_top.sv
rtl/core/sda_checker.sv
tb/tb.sv
